/* sv/ring_frame_relay_crc8_top_assert.svh */
// Assertion macros for the verification checker of the frame relay.
// Expects clk and rst_n to be visible where a macro is used.
`ifndef RING_FRAME_RELAY_CRC8_TOP_ASSERT_SVH
`define RING_FRAME_RELAY_CRC8_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RFR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define RFR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/rfr_pkg.sv */
// Shared types, codes and the CRC-8 step function for the frame relay.
// No dependencies; used by every RTL module and the checker.
package rfr_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned BODY_LEN    = 7;

    localparam logic       OP_BYTE = 1'b0;
    localparam logic       OP_TICK = 1'b1;

    localparam logic [1:0] KIND_FWD      = 2'd0;
    localparam logic [1:0] KIND_HB       = 2'd1;
    localparam logic [1:0] KIND_CRC_ERR  = 2'd2;
    localparam logic [1:0] KIND_NOT_ADDR = 2'd3;

    localparam logic [1:0] REG_NODE_ID   = 2'd0;
    localparam logic [1:0] REG_HB_DEST   = 2'd1;
    localparam logic [1:0] REG_HB_PERIOD = 2'd2;

    localparam logic [7:0]  CRC_POLY        = 8'h07;
    localparam logic [7:0]  HB_FUNCTION     = 8'h01;
    localparam logic [3:0]  NODE_ID_RESET   = 4'd3;
    localparam logic [7:0]  HB_DEST_RESET   = 8'd7;
    localparam logic [15:0] HB_PERIOD_RESET = 16'd5000;
    localparam logic [7:0]  PACKET_ID_RESET = 8'd1;

    typedef struct packed {
        logic [3:0]  node_id;
        logic [7:0]  hb_dest;
        logic [15:0] hb_period;
    } cfg_t;

    // One frame job: byte 0 of the body sits in the low bits.
    typedef struct packed {
        logic [1:0]            kind;
        logic [8*BODY_LEN-1:0] body;
    } cmd_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++)
        begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

/* sv/rfr_front.sv */
// Front end: gathers received bytes, checks the CRC, counts ticks and turns
// each finished frame or heartbeat into a job. Depends on rfr_pkg.
module rfr_front (
    input  logic          clk,
    input  logic          rst_n,
    input  rfr_pkg::cfg_t cfg,
    input  logic          push,
    input  logic          operation,
    input  logic [7:0]    rx_byte,
    input  logic          q_full,
    output logic          cmd_valid,
    output rfr_pkg::cmd_t cmd
);

    logic [7:0]  store_reg [rfr_pkg::BODY_LEN];
    logic [2:0]  byte_count_reg, byte_count_next;
    logic [7:0]  crc_reg, crc_next;
    logic [15:0] tick_count_reg, tick_count_next;
    logic [7:0]  packet_id_reg, packet_id_next;
    logic        accept;
    logic        store_we;
    logic [15:0] tick_inc;
    logic [7:0]  crc_base;
    logic [7:0]  path_bit;
    logic [7:0]  node_byte;
    logic [8*rfr_pkg::BODY_LEN-1:0] body_fwd;
    logic [8*rfr_pkg::BODY_LEN-1:0] body_hb;

    assign accept    = push && !q_full;
    assign node_byte = {4'd0, cfg.node_id};
    assign tick_inc  = (tick_count_reg != 16'hFFFF) ? tick_count_reg + 16'd1 : tick_count_reg;
    assign crc_base  = (byte_count_reg == 3'd0) ? 8'h00 : crc_reg;
    // Node ids outside one to eight own no bit of the path byte.
    assign path_bit  = (cfg.node_id >= 4'd1 && cfg.node_id <= 4'd8)
                       ? (8'd1 << (cfg.node_id - 4'd1)) : 8'd0;
    assign body_fwd  = {store_reg[6] | path_bit, store_reg[5], store_reg[4], store_reg[3],
                        store_reg[2], node_byte, store_reg[0]};
    assign body_hb   = {8'd0, 8'd0, 8'd0, rfr_pkg::HB_FUNCTION, cfg.hb_dest, node_byte,
                        packet_id_reg};

    always_comb
    begin
        byte_count_next = byte_count_reg;
        crc_next        = crc_reg;
        tick_count_next = tick_count_reg;
        packet_id_next  = packet_id_reg;
        store_we        = 1'b0;
        cmd_valid       = 1'b0;
        cmd             = '0;
        if (accept)
        begin
            if (operation == rfr_pkg::OP_TICK)
            begin
                if (tick_inc >= cfg.hb_period)
                begin
                    cmd_valid       = 1'b1;
                    cmd.kind        = rfr_pkg::KIND_HB;
                    cmd.body        = body_hb;
                    tick_count_next = 16'd0;
                    packet_id_next  = packet_id_reg + 8'd1;
                end
                else
                begin
                    tick_count_next = tick_inc;
                end
            end
            else if (byte_count_reg != 3'(rfr_pkg::BODY_LEN))
            begin
                store_we        = 1'b1;
                crc_next        = rfr_pkg::crc8_byte(crc_base, rx_byte);
                byte_count_next = byte_count_reg + 3'd1;
            end
            else
            begin
                // The eighth byte is the check byte; judge the frame.
                byte_count_next = 3'd0;
                cmd_valid       = 1'b1;
                if (crc_reg != rx_byte)
                begin
                    cmd.kind = rfr_pkg::KIND_CRC_ERR;
                end
                else if (store_reg[2] != node_byte)
                begin
                    cmd.kind = rfr_pkg::KIND_NOT_ADDR;
                end
                else
                begin
                    cmd.kind = rfr_pkg::KIND_FWD;
                    cmd.body = body_fwd;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= 3'd0;
            crc_reg        <= 8'h00;
            tick_count_reg <= 16'd0;
            packet_id_reg  <= rfr_pkg::PACKET_ID_RESET;
        end
        else
        begin
            byte_count_reg <= byte_count_next;
            crc_reg        <= crc_next;
            tick_count_reg <= tick_count_next;
            packet_id_reg  <= packet_id_next;
        end
    end

    for (genvar i = 0; i < rfr_pkg::BODY_LEN; i++)
    begin : g_store
        always_ff @(posedge clk)
        begin
            if (store_we && byte_count_reg == 3'(i))
            begin
                store_reg[i] <= rx_byte;
            end
        end
    end

endmodule

/* sv/rfr_cmdq.sv */
// Short job queue between the front end and the transmit back end.
// Depends on rfr_pkg for the job type.
module rfr_cmdq #(
    parameter int unsigned DEPTH = rfr_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr,
    input  rfr_pkg::cmd_t wr_data,
    input  logic          rd,
    output rfr_pkg::cmd_t rd_data,
    output logic          empty,
    output logic          full
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    rfr_pkg::cmd_t    entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign empty   = (count_reg == CNT_W'(0));
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign do_wr   = wr && !full;
    assign do_rd   = rd && !empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* sv/rfr_back.sv */
// Back end: takes one job from the queue and sends its words, computing the
// trailing CRC one byte per cycle unless output stalls. Depends on rfr_pkg.
module rfr_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  rfr_pkg::cmd_t q_head,
    output logic          q_pop,
    input  logic          pop,
    output logic          empty,
    output logic [1:0]    kind,
    output logic [7:0]    tx_byte,
    output logic          last
);

    logic                           busy_reg, busy_next;
    logic [2:0]                     idx_reg, idx_next;
    logic [1:0]                     job_kind_reg, job_kind_next;
    logic [8*rfr_pkg::BODY_LEN-1:0] body_reg, body_next;
    logic [7:0]                     crc_reg, crc_next;
    logic                           ovalid_reg, ovalid_next;
    logic [1:0]                     okind_reg, okind_next;
    logic [7:0]                     obyte_reg, obyte_next;
    logic                           olast_reg, olast_next;
    logic                           out_free;

    assign out_free = !ovalid_reg || pop;
    assign q_pop    = !busy_reg && !q_empty;
    assign empty    = !ovalid_reg;
    assign kind     = okind_reg;
    assign tx_byte  = obyte_reg;
    assign last     = olast_reg;

    always_comb
    begin
        busy_next     = busy_reg;
        idx_next      = idx_reg;
        job_kind_next = job_kind_reg;
        body_next     = body_reg;
        crc_next      = crc_reg;
        ovalid_next   = ovalid_reg;
        okind_next    = okind_reg;
        obyte_next    = obyte_reg;
        olast_next    = olast_reg;

        if (out_free)
        begin
            ovalid_next = 1'b0;
            if (busy_reg)
            begin
                ovalid_next = 1'b1;
                okind_next  = job_kind_reg;
                case (job_kind_reg) inside
                    rfr_pkg::KIND_CRC_ERR, rfr_pkg::KIND_NOT_ADDR:
                    begin
                        obyte_next = 8'h00;
                        olast_next = 1'b1;
                        busy_next  = 1'b0;
                    end
                    default:
                    begin
                        if (idx_reg != 3'(rfr_pkg::BODY_LEN))
                        begin
                            obyte_next = body_reg[7:0];
                            olast_next = 1'b0;
                            crc_next   = rfr_pkg::crc8_byte(crc_reg, body_reg[7:0]);
                            body_next  = body_reg >> 8;
                            idx_next   = idx_reg + 3'd1;
                        end
                        else
                        begin
                            obyte_next = crc_reg;
                            olast_next = 1'b1;
                            busy_next  = 1'b0;
                        end
                    end
                endcase
            end
        end

        if (q_pop)
        begin
            busy_next     = 1'b1;
            idx_next      = 3'd0;
            job_kind_next = q_head.kind;
            body_next     = q_head.body;
            crc_next      = 8'h00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        job_kind_reg <= job_kind_next;
        body_reg     <= body_next;
        crc_reg      <= crc_next;
        okind_reg    <= okind_next;
        obyte_reg    <= obyte_next;
        olast_reg    <= olast_next;
    end

endmodule

/* sv/ring_frame_relay_crc8_top.sv */
// Top level of the CRC-8 framed relay node: configuration registers and the
// front end, job queue and back end. Depends on rfr_pkg and the rfr_* modules.
//
// The front end takes one item per cycle: a received byte or a tick never
// waits unless the job queue is full. A finished frame becomes one job; the
// back end loads a job and then sends its result words in order: eight for
// a forwarded or heartbeat frame, the last of them the CRC, and a single
// zero word for a report. The output register lets the next word wait
// while the front end keeps accepting.
// Registers sit at byte addresses 0 (node id), 4 (heartbeat destination)
// and 8 (heartbeat period); write them only while the block is idle.
module ring_frame_relay_crc8_top #(
    parameter int unsigned QUEUE_DEPTH = rfr_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        operation,
    input  logic [7:0]  rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  kind,
    output logic [7:0]  tx_byte,
    output logic        last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [3:0]    node_id_reg;
    logic [7:0]    hb_dest_reg;
    logic [15:0]   hb_period_reg;
    logic          cfg_wr;
    rfr_pkg::cfg_t cfg;
    logic          cmd_valid;
    rfr_pkg::cmd_t cmd;
    rfr_pkg::cmd_t q_head;
    logic          q_empty;
    logic          q_full;
    logic          q_pop;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign full   = q_full;
    assign cfg    = '{node_id: node_id_reg, hb_dest: hb_dest_reg, hb_period: hb_period_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_id_reg   <= rfr_pkg::NODE_ID_RESET;
            hb_dest_reg   <= rfr_pkg::HB_DEST_RESET;
            hb_period_reg <= rfr_pkg::HB_PERIOD_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                rfr_pkg::REG_NODE_ID:   node_id_reg   <= pwdata[3:0];
                rfr_pkg::REG_HB_DEST:   hb_dest_reg   <= pwdata[7:0];
                rfr_pkg::REG_HB_PERIOD: hb_period_reg <= pwdata[15:0];
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            rfr_pkg::REG_NODE_ID:   prdata = {28'd0, node_id_reg};
            rfr_pkg::REG_HB_DEST:   prdata = {24'd0, hb_dest_reg};
            rfr_pkg::REG_HB_PERIOD: prdata = {16'd0, hb_period_reg};
            default:                prdata = 32'd0;
        endcase
    end

    rfr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .push      (push),
        .operation (operation),
        .rx_byte   (rx_byte),
        .q_full    (q_full),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    rfr_cmdq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_cmdq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (cmd_valid),
        .wr_data (cmd),
        .rd      (q_pop),
        .rd_data (q_head),
        .empty   (q_empty),
        .full    (q_full)
    );

    rfr_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .kind    (kind),
        .tx_byte (tx_byte),
        .last    (last)
    );

endmodule

/* sv/rfr_checker.sv */
// Port-level checker for the frame relay, bound to the top level.
// Depends on rfr_pkg and ring_frame_relay_crc8_top_assert.svh.
`include "ring_frame_relay_crc8_top_assert.svh"

module rfr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic [1:0] kind,
    input logic [7:0] tx_byte,
    input logic       last
);

    // A word that is not taken stays on the ports unchanged.
    `RFR_ASSERT_NXT(a_out_hold, !empty && !pop, !empty && $stable(kind) && $stable(tx_byte) && $stable(last), "result word changed while stalled")

    // Reports are single words with a zero byte.
    `RFR_ASSERT_IMP(a_report_single, !empty && (kind == rfr_pkg::KIND_CRC_ERR || kind == rfr_pkg::KIND_NOT_ADDR), last && tx_byte == 8'h00, "report is not a single zero word")

    // Within a frame the next word follows right after a pop.
    `RFR_ASSERT_NXT(a_frame_no_gap, pop && !empty && !last, !empty, "gap inside an outgoing frame")

    // All words of one frame carry the same kind.
    `RFR_ASSERT_NXT(a_frame_kind, pop && !empty && !last, kind == $past(kind), "kind changed inside a frame")

endmodule

bind ring_frame_relay_crc8_top rfr_checker u_rfr_checker (.*);
